// File: src/chbd_pkg.sv
// Shared types, codes and constants of the chunked body decoder.
package chbd_pkg;

  localparam int unsigned DEFAULT_MAX_SIZE_DIGITS = 8;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned SKIP_W   = 2;
  localparam int unsigned STATUS_W = 3;

  localparam logic [BYTE_W-1:0] CHAR_CR       = 8'h0d;
  localparam logic [BYTE_W-1:0] CHAR_NUL      = 8'h00;
  localparam logic [BYTE_W-1:0] DEC_BELOW     = 8'h2f;
  localparam logic [BYTE_W-1:0] DEC_ABOVE     = 8'h3a;
  localparam logic [BYTE_W-1:0] ALPHA_BELOW   = 8'h60;
  localparam logic [BYTE_W-1:0] ALPHA_ABOVE   = 8'h67;
  localparam logic [BYTE_W-1:0] DEC_OFFSET    = 8'd48;
  localparam logic [BYTE_W-1:0] ALPHA_OFFSET  = 8'd87;

  localparam logic [SKIP_W-1:0] SKIP_AFTER_SIZE = 2'd1;
  localparam logic [SKIP_W-1:0] SKIP_TRAILER    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_RUNNING    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DONE       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_HEX    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY_SIZE = 3'd5;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [7:0] {
    PH_SIZE     = 8'b0000_0001,
    PH_SKIP     = 8'b0000_0010,
    PH_DATA     = 8'b0000_0100,
    PH_TRAIL    = 8'b0000_1000,
    PH_DONE     = 8'b0001_0000,
    PH_BAD_HEX  = 8'b0010_0000,
    PH_TOO_MANY = 8'b0100_0000,
    PH_EMPTY    = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] body_byte;
    logic              final_byte;
  } in_beat_t;

  typedef struct packed {
    logic                payload_valid;
    logic [BYTE_W-1:0]   payload_byte;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    decoded_length;
    logic                finished;
  } out_beat_t;

  // Classified byte handed from the front to the back.
  typedef struct packed {
    logic [BYTE_W-1:0] body_byte;
    logic              final_byte;
    logic              is_term;
    logic              is_digit;
    logic [NIB_W-1:0]  nibble;
  } item_t;

endpackage

// File: src/chbd_front.sv
// Front end: classifies each body byte and queues it for the back end.
module chbd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  chbd_pkg::in_beat_t in_data,
  output logic              q_valid,
  output chbd_pkg::item_t   q_item,
  input  logic              q_pop
);

  chbd_pkg::item_t                   mem_r [chbd_pkg::QUEUE_DEPTH];
  logic [chbd_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [chbd_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [chbd_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  chbd_pkg::item_t                   cls;
  logic                              is_dec, is_alpha, push;
  logic [chbd_pkg::BYTE_W-1:0]       diff;

  always_comb begin
    is_dec   = (in_data.body_byte > chbd_pkg::DEC_BELOW) &&
               (in_data.body_byte < chbd_pkg::DEC_ABOVE);
    is_alpha = (in_data.body_byte > chbd_pkg::ALPHA_BELOW) &&
               (in_data.body_byte < chbd_pkg::ALPHA_ABOVE);
    diff     = is_dec ? (in_data.body_byte - chbd_pkg::DEC_OFFSET)
                      : (in_data.body_byte - chbd_pkg::ALPHA_OFFSET);
    cls.body_byte  = in_data.body_byte;
    cls.final_byte = in_data.final_byte;
    cls.is_term    = (in_data.body_byte == chbd_pkg::CHAR_CR) ||
                     (in_data.body_byte == chbd_pkg::CHAR_NUL);
    cls.is_digit   = is_dec || is_alpha;
    cls.nibble     = diff[chbd_pkg::NIB_W-1:0];
  end

  assign in_stall = (cnt_r == chbd_pkg::QCNT_W'(chbd_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + chbd_pkg::QCNT_W'(push) - chbd_pkg::QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  assign q_item = mem_r[rd_ptr_r];

endmodule

// File: src/chbd_back.sv
// Back end: chunk framing state machine, counters and the result register.
module chbd_back #(
  parameter int unsigned MAX_SIZE_DIGITS = chbd_pkg::DEFAULT_MAX_SIZE_DIGITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  chbd_pkg::item_t     q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output chbd_pkg::out_beat_t out_data
);

  localparam int unsigned DIG_W = $clog2(MAX_SIZE_DIGITS + 1);

  chbd_pkg::phase_t                phase_r, phase_nxt;
  logic [chbd_pkg::LEN_W-1:0]      acc_r, acc_nxt;
  logic [DIG_W-1:0]                dcnt_r, dcnt_nxt;
  logic [chbd_pkg::LEN_W-1:0]      brem_r, brem_nxt, brem_dec;
  logic [chbd_pkg::SKIP_W-1:0]     skip_r, skip_nxt, skip_dec;
  logic [chbd_pkg::LEN_W-1:0]      total_r, total_nxt;
  logic                            out_valid_r, out_valid_nxt;
  chbd_pkg::out_beat_t             out_r, res;
  logic                            load;
  logic [chbd_pkg::STATUS_W-1:0]   st;

  assign load  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = load;

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    dcnt_nxt  = dcnt_r;
    brem_nxt  = brem_r;
    skip_nxt  = skip_r;
    total_nxt = total_r;
    skip_dec  = skip_r - 1'b1;
    brem_dec  = (brem_r != '0) ? brem_r - 1'b1 : brem_r;
    res.payload_valid = 1'b0;
    res.payload_byte  = '0;

    unique case (phase_r)
      chbd_pkg::PH_SIZE: begin
        if (q_item.is_term) begin
          if (dcnt_r == '0) begin
            phase_nxt = chbd_pkg::PH_EMPTY;
          end else if (acc_r == '0) begin
            phase_nxt = chbd_pkg::PH_DONE;
          end else begin
            brem_nxt  = acc_r;
            acc_nxt   = '0;
            dcnt_nxt  = '0;
            skip_nxt  = chbd_pkg::SKIP_AFTER_SIZE;
            phase_nxt = chbd_pkg::PH_SKIP;
          end
        end else if (dcnt_r >= DIG_W'(MAX_SIZE_DIGITS)) begin
          phase_nxt = chbd_pkg::PH_TOO_MANY;
        end else if (q_item.is_digit) begin
          acc_nxt  = {acc_r[chbd_pkg::LEN_W-chbd_pkg::NIB_W-1:0], q_item.nibble};
          dcnt_nxt = dcnt_r + 1'b1;
        end else begin
          phase_nxt = chbd_pkg::PH_BAD_HEX;
        end
      end
      chbd_pkg::PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          if (brem_r == '0) begin
            phase_nxt = chbd_pkg::PH_TRAIL;
            skip_nxt  = chbd_pkg::SKIP_TRAILER;
          end else begin
            phase_nxt = chbd_pkg::PH_DATA;
          end
        end
      end
      chbd_pkg::PH_DATA: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = q_item.body_byte;
        if (total_r != '1) begin
          total_nxt = total_r + 1'b1;
        end
        brem_nxt = brem_dec;
        if (brem_dec == '0) begin
          skip_nxt  = chbd_pkg::SKIP_TRAILER;
          phase_nxt = chbd_pkg::PH_TRAIL;
        end
      end
      chbd_pkg::PH_TRAIL: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = chbd_pkg::PH_SIZE;
        end
      end
      default: begin
      end
    endcase

    unique case (phase_nxt)
      chbd_pkg::PH_DONE:     st = chbd_pkg::ST_DONE;
      chbd_pkg::PH_BAD_HEX:  st = chbd_pkg::ST_BAD_HEX;
      chbd_pkg::PH_TOO_MANY: st = chbd_pkg::ST_TOO_MANY;
      chbd_pkg::PH_EMPTY:    st = chbd_pkg::ST_EMPTY_SIZE;
      default:               st = chbd_pkg::ST_RUNNING;
    endcase

    // The end of the body is judged on where the framing stands after this byte.
    if (q_item.final_byte && (st == chbd_pkg::ST_RUNNING)) begin
      if ((phase_nxt == chbd_pkg::PH_TRAIL) ||
          ((phase_nxt == chbd_pkg::PH_SIZE) && (acc_nxt == '0))) begin
        st = chbd_pkg::ST_DONE;
      end else begin
        st = chbd_pkg::ST_TRUNCATED;
      end
    end

    res.status         = st;
    res.decoded_length = total_nxt;
    res.finished       = (st != chbd_pkg::ST_RUNNING);

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= chbd_pkg::PH_SIZE;
      acc_r       <= '0;
      dcnt_r      <= '0;
      brem_r      <= '0;
      skip_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load) begin
        if (q_item.final_byte) begin
          phase_r <= chbd_pkg::PH_SIZE;
          acc_r   <= '0;
          dcnt_r  <= '0;
          brem_r  <= '0;
          skip_r  <= '0;
          total_r <= '0;
        end else begin
          phase_r <= phase_nxt;
          acc_r   <= acc_nxt;
          dcnt_r  <= dcnt_nxt;
          brem_r  <= brem_nxt;
          skip_r  <= skip_nxt;
          total_r <= total_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: src/http_chunked_body_decoder_core.sv
// Top level of the HTTP chunked body decoder.
//
//   Channel  Direction  Handshake           Beat contents
//   in_      input      in_valid/in_stall   one raw body byte and its final-byte mark
//   out_     output     out_valid/out_stall one result: payload byte, status, length
//
// One beat is accepted per clock cycle while in_stall is low, and each input beat
// yields exactly one result beat. An accepted beat is written into the two-entry
// classification queue at the accepting edge and, if the output register is free
// or being drained, the framing engine moves its result from the queue into that
// register, from which it leaves on the out_ channel.
// Reset is synchronous and active low; it empties the queue, drops the output
// beat and returns the framing engine to the start of a size line.
// A stall on the output holds the result register; the queue then absorbs up
// to two further input beats before in_stall rises.
module http_chunked_body_decoder_core #(
  parameter int unsigned MAX_SIZE_DIGITS = chbd_pkg::DEFAULT_MAX_SIZE_DIGITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  chbd_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output chbd_pkg::out_beat_t out_data
);

  // Classified beats waiting between the front end and the framing engine.
  logic            q_valid;
  logic            q_pop;
  chbd_pkg::item_t q_item;

  // The front end decodes the byte (line terminator, hex digit and its
  // value) before the beat enters the queue, so the engine only has to
  // update its phase and counters.
  chbd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // The back end walks the chunk framing, keeps the running payload count
  // and forms the result beat in its output register. It pulls from the
  // queue whenever that register is empty or being drained.
  chbd_back #(
    .MAX_SIZE_DIGITS (MAX_SIZE_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The finished flag must agree with the status code of the same beat.
  a_finished_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.finished == (out_data.status != chbd_pkg::ST_RUNNING)))
    else $error("finished flag disagrees with status");

  // A non-payload beat carries a zero byte.
  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.payload_valid) |-> (out_data.payload_byte == '0))
    else $error("payload byte not zero on a non-payload beat");

  // Payload is never emitted alongside a framing error.
  a_payload_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.payload_valid) |->
      ((out_data.status == chbd_pkg::ST_RUNNING) ||
       (out_data.status == chbd_pkg::ST_DONE) ||
       (out_data.status == chbd_pkg::ST_TRUNCATED)))
    else $error("payload beat carries an error status");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench of the HTTP chunked body decoder core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [chbd_pkg::BYTE_W-1:0] LINE_FEED = 8'h0a;

  // Expected-result store and a cycle-free model of the framing engine. Every
  // body beat accepted by the block is run through the model here, and every
  // result beat taken from the block is checked against the oldest prediction.
  class chunk_decode_board;
    chbd_pkg::phase_t              stage;
    logic [chbd_pkg::LEN_W-1:0]    size_acc;
    logic [3:0]                    size_digits;
    logic [chbd_pkg::LEN_W-1:0]    chunk_left;
    logic [chbd_pkg::SKIP_W-1:0]   skip_left;
    logic [chbd_pkg::LEN_W-1:0]    length_sum;
    chbd_pkg::out_beat_t           decoded_due[$];
    int                            fails;

    function new();
      fails = 0;
      clear();
    endfunction

    function void clear();
      stage       = chbd_pkg::PH_SIZE;
      size_acc    = '0;
      size_digits = '0;
      chunk_left  = '0;
      skip_left   = '0;
      length_sum  = '0;
    endfunction

    function int pending();
      return decoded_due.size();
    endfunction

    function logic [chbd_pkg::STATUS_W-1:0] status_for(chbd_pkg::phase_t ph);
      case (ph)
        chbd_pkg::PH_DONE:     return chbd_pkg::ST_DONE;
        chbd_pkg::PH_BAD_HEX:  return chbd_pkg::ST_BAD_HEX;
        chbd_pkg::PH_TOO_MANY: return chbd_pkg::ST_TOO_MANY;
        chbd_pkg::PH_EMPTY:    return chbd_pkg::ST_EMPTY_SIZE;
        default:               return chbd_pkg::ST_RUNNING;
      endcase
    endfunction

    function void note_body_beat(chbd_pkg::in_beat_t beat);
      logic [chbd_pkg::BYTE_W-1:0]   b;
      logic [chbd_pkg::STATUS_W-1:0] st;
      chbd_pkg::out_beat_t           res;
      b   = beat.body_byte;
      res = '0;
      case (stage)
        chbd_pkg::PH_SIZE: begin
          if (b == chbd_pkg::CHAR_CR || b == chbd_pkg::CHAR_NUL) begin
            if (size_digits == 0) begin
              stage = chbd_pkg::PH_EMPTY;
            end else if (size_acc == 0) begin
              stage = chbd_pkg::PH_DONE;
            end else begin
              chunk_left  = size_acc;
              size_acc    = '0;
              size_digits = '0;
              skip_left   = chbd_pkg::SKIP_AFTER_SIZE;
              stage       = chbd_pkg::PH_SKIP;
            end
          end else if (size_digits >= chbd_pkg::DEFAULT_MAX_SIZE_DIGITS) begin
            stage = chbd_pkg::PH_TOO_MANY;
          end else if (b > chbd_pkg::DEC_BELOW && b < chbd_pkg::DEC_ABOVE) begin
            size_acc    = {size_acc[chbd_pkg::LEN_W-5:0], 4'(b - chbd_pkg::DEC_OFFSET)};
            size_digits = size_digits + 4'd1;
          end else if (b > chbd_pkg::ALPHA_BELOW && b < chbd_pkg::ALPHA_ABOVE) begin
            size_acc    = {size_acc[chbd_pkg::LEN_W-5:0], 4'(b - chbd_pkg::ALPHA_OFFSET)};
            size_digits = size_digits + 4'd1;
          end else begin
            stage = chbd_pkg::PH_BAD_HEX;
          end
        end
        chbd_pkg::PH_SKIP: begin
          skip_left = skip_left - 2'd1;
          if (skip_left == 0) begin
            stage = (chunk_left == 0) ? chbd_pkg::PH_TRAIL : chbd_pkg::PH_DATA;
          end
          if (stage == chbd_pkg::PH_TRAIL) skip_left = chbd_pkg::SKIP_TRAILER;
        end
        chbd_pkg::PH_DATA: begin
          res.payload_valid = 1'b1;
          res.payload_byte  = b;
          if (length_sum != '1) length_sum = length_sum + 1;
          if (chunk_left != 0) chunk_left = chunk_left - 1;
          if (chunk_left == 0) begin
            skip_left = chbd_pkg::SKIP_TRAILER;
            stage     = chbd_pkg::PH_TRAIL;
          end
        end
        chbd_pkg::PH_TRAIL: begin
          skip_left = skip_left - 2'd1;
          if (skip_left == 0) stage = chbd_pkg::PH_SIZE;
        end
        default: ;
      endcase

      st = status_for(stage);
      if (beat.final_byte && st == chbd_pkg::ST_RUNNING) begin
        if (stage == chbd_pkg::PH_TRAIL ||
            (stage == chbd_pkg::PH_SIZE && size_acc == 0)) st = chbd_pkg::ST_DONE;
        else st = chbd_pkg::ST_TRUNCATED;
      end
      res.status         = st;
      res.decoded_length = length_sum;
      res.finished       = (st != chbd_pkg::ST_RUNNING);
      decoded_due.push_back(res);
      if (beat.final_byte) clear();
    endfunction

    function int field_differs(string name, logic [chbd_pkg::LEN_W-1:0] exp_v,
                               logic [chbd_pkg::LEN_W-1:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
        return 1;
      end
      return 0;
    endfunction

    function void check_decoded_beat(chbd_pkg::out_beat_t got);
      chbd_pkg::out_beat_t want;
      int                  bad;
      if (decoded_due.size() == 0) begin
        $display("%0t: result beat with none expected, expected nothing actual %0h",
                 $time, got);
        fails++;
        return;
      end
      want = decoded_due.pop_front();
      bad  = 0;
      bad += field_differs("payload_valid", want.payload_valid, got.payload_valid);
      bad += field_differs("payload_byte", want.payload_byte, got.payload_byte);
      bad += field_differs("status", want.status, got.status);
      bad += field_differs("decoded_length", want.decoded_length, got.decoded_length);
      bad += field_differs("finished", want.finished, got.finished);
      if (bad != 0) fails++;
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  chbd_pkg::in_beat_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  chbd_pkg::out_beat_t out_data;

  chunk_decode_board board = new();

  // Idling knobs, in percent of cycles; the main sequence changes them by phase.
  int in_idle_pct   = 0;
  int out_stall_pct = 0;

  // Body under construction, and a count of beats that the block actually acts on.
  chbd_pkg::in_beat_t body_q[$];
  int                 live_beats = 0;
  bit                 tail_mode  = 1'b0;

  http_chunked_body_decoder_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver stalls at random; the decision for the next edge is made at
  // this edge, so the block always sees a settled value.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  // Result monitor. Values are read as they stood just before the edge, which
  // is exactly what the block's registers sampled.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_decoded_beat(out_data);
  end

  // Hard stop well beyond the slowest legal run of this stimulus.
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [chbd_pkg::BYTE_W-1:0] hex_char(logic [3:0] nib);
    return (nib < 4'd10) ? chbd_pkg::DEC_OFFSET + nib : chbd_pkg::ALPHA_OFFSET + nib;
  endfunction

  function automatic bit is_hex(logic [chbd_pkg::BYTE_W-1:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f");
  endfunction

  // Any byte that can neither extend nor end a size line.
  function automatic logic [chbd_pkg::BYTE_W-1:0] bad_char();
    logic [chbd_pkg::BYTE_W-1:0] c;
    do c = 8'($urandom_range(0, 255));
    while (is_hex(c) || c == chbd_pkg::CHAR_CR || c == chbd_pkg::CHAR_NUL);
    return c;
  endfunction

  function automatic int min_digits(logic [chbd_pkg::LEN_W-1:0] v);
    int n;
    n = 1;
    while (n < 8 && (v >> (4 * n)) != 0) n++;
    return n;
  endfunction

  task automatic push_byte(logic [chbd_pkg::BYTE_W-1:0] b);
    body_q.push_back('{body_byte: b, final_byte: 1'b0});
    if (!tail_mode) live_beats++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic put_size(logic [chbd_pkg::LEN_W-1:0] value, int ndig);
    for (int i = ndig - 1; i >= 0; i--) push_byte(hex_char(value[4*i +: 4]));
  endtask

  task automatic put_line_end();
    push_byte(chbd_pkg::CHAR_CR);
    push_byte(LINE_FEED);
  endtask

  // One beat on the input channel. The sender may idle first; the beat is
  // then held until an edge at which the block is not stalling.
  task automatic send_beat(chbd_pkg::in_beat_t beat);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    board.note_body_beat(beat);
  endtask

  // Marks the last byte of the body as final and sends the whole body.
  task automatic send_body();
    body_q[body_q.size() - 1].final_byte = 1'b1;
    foreach (body_q[i]) send_beat(body_q[i]);
    body_q.delete();
    tail_mode = 1'b0;
  endtask

  function automatic logic [chbd_pkg::LEN_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 300);
  endfunction

  // A size line that the block must reject, followed by a few bytes that it
  // only ignores.
  task automatic put_broken_line();
    int mode;
    mode = $urandom_range(0, 2);
    case (mode)
      0: begin
        repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom_range(0, 15))));
        push_byte(bad_char());
      end
      1: begin
        // Eight digits held: a ninth byte that is not a line terminator is refused.
        repeat (8) push_byte(hex_char(4'($urandom_range(0, 15))));
        push_byte(($urandom_range(0, 1) != 0) ? hex_char(4'($urandom_range(0, 15)))
                                                : bad_char());
      end
      default: begin
        push_byte(($urandom_range(0, 3) != 0) ? chbd_pkg::CHAR_CR : chbd_pkg::CHAR_NUL);
      end
    endcase
    tail_mode = 1'b1;
    repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
  endtask

  // One random body: a few chunks and the closing zero chunk, mostly well
  // formed with random payload, sometimes with a rejected size line, and
  // sometimes cut short at a random byte.
  task automatic send_random_body();
    int                         nchunks;
    int                         err_at;
    int                         ndig;
    int                         cut;
    logic [chbd_pkg::LEN_W-1:0] size;
    nchunks = $urandom_range(0, 4);
    err_at  = ($urandom_range(0, 99) < 15) ? $urandom_range(0, nchunks) : -1;
    for (int k = 0; k <= nchunks; k++) begin
      if (k == err_at) begin
        put_broken_line();
        break;
      end
      size = (k == nchunks) ? '0 : pick_size();
      ndig = min_digits(size);
      if ($urandom_range(0, 3) == 0) ndig = $urandom_range(ndig, 8);
      put_size(size, ndig);
      push_byte(($urandom_range(0, 4) != 0) ? chbd_pkg::CHAR_CR : chbd_pkg::CHAR_NUL);
      // Once the closing size line is ended the rest is ignored by the block.
      if (k == nchunks) tail_mode = 1'b1;
      push_byte(($urandom_range(0, 4) != 0) ? LINE_FEED : 8'($urandom_range(0, 255)));
      for (int i = 0; i < size; i++) push_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) != 0) begin
        put_line_end();
      end else begin
        push_byte(8'($urandom_range(0, 255)));
        push_byte(8'($urandom_range(0, 255)));
      end
    end
    if (err_at < 0 && $urandom_range(0, 99) < 15) begin
      cut = $urandom_range(0, body_q.size() - 1);
      while (body_q.size() > cut + 1) begin
        void'(body_q.pop_back());
        live_beats--;
      end
    end
    send_body();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: a lazy sender, a receiver that stalls most of the time.
    in_idle_pct   = 28;
    out_stall_pct = 80;

    // Directed bodies. The smallest legal body: the closing chunk alone.
    push_text("0");
    put_line_end();
    put_line_end();
    send_body();

    // A two-byte chunk carrying the byte extremes, closed by a NUL-ended
    // zero line on which the body finishes.
    push_text("2");
    put_line_end();
    push_byte(8'h00);
    push_byte(8'hff);
    put_line_end();
    push_text("0");
    push_byte(chbd_pkg::CHAR_NUL);
    send_body();

    // Eight digits covering the digit range; the body ends on the CR, which
    // leaves it truncated.
    push_text("a9f0000e");
    push_byte(chbd_pkg::CHAR_CR);
    send_body();

    // Bytes just outside the decimal and letter ranges, and an empty size line.
    push_text("/");
    send_body();
    push_text("g");
    send_body();
    push_byte(chbd_pkg::CHAR_CR);
    send_body();

    // A ninth character after eight digits are held.
    push_text("12345678:");
    send_body();

    while (live_beats < 350) send_random_body();

    // Phase two: the roles of sender and receiver swapped.
    in_idle_pct   = 80;
    out_stall_pct = 28;
    while (live_beats < 700) send_random_body();

    // Phase three: full rate on both sides.
    in_idle_pct   = 0;
    out_stall_pct = 0;
    while (live_beats < 1050) send_random_body();

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    // The block holds at most three beats; a few extra cycles expose any stray result.
    repeat (10) @(posedge clk);
    if (board.fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
src/chbd_pkg.sv
src/chbd_front.sv
src/chbd_back.sv
src/http_chunked_body_decoder_core.sv
sim/tb_top.sv
